### sv/easc_pkg.sv
// Shared types, constants and character classes for the address syntax checker.
`default_nettype none
package easc_pkg;

  localparam int MAX_ADDRESS_LENGTH = 255;
  localparam int CNT_W              = $clog2(MAX_ADDRESS_LENGTH + 1);
  localparam int LOCAL_LIMIT        = 64;
  localparam int LABEL_LIMIT        = 64;
  localparam int MIN_LITERAL_SPAN   = 10;
  localparam int TOP_LABEL_SPAN     = 3;
  localparam int CODE_W             = 16;
  localparam int DEC_W              = 10;
  localparam int ADDR_W             = 3;

  localparam logic [1:0] KIND_ALPHA = 2'b01;
  localparam logic [1:0] KIND_DIGIT = 2'b10;

  localparam logic [CODE_W-1:0] CH_QUOTE   = 16'h0022;
  localparam logic [CODE_W-1:0] CH_BSLASH  = 16'h005C;
  localparam logic [CODE_W-1:0] CH_AT      = 16'h0040;
  localparam logic [CODE_W-1:0] CH_DOT     = 16'h002E;
  localparam logic [CODE_W-1:0] CH_HYPHEN  = 16'h002D;
  localparam logic [CODE_W-1:0] CH_LBRACK  = 16'h005B;
  localparam logic [CODE_W-1:0] CH_RBRACK  = 16'h005D;
  localparam logic [CODE_W-1:0] CH_COLON   = 16'h003A;
  localparam logic [CODE_W-1:0] CH_SIX     = 16'h0036;

  // Configuration register indexes
  localparam logic REG_SINGLE_LABEL = 1'b0;
  localparam logic REG_INTL         = 1'b1;

  typedef enum logic [3:0] {
    PH_START,
    PH_QUOTED,
    PH_QUOTE_END,
    PH_ATOM_START,
    PH_ATOM,
    PH_DOM_START,
    PH_LIT_FIRST,
    PH_LABEL_START,
    PH_LABEL,
    PH_TAG,
    PH_V4,
    PH_V6,
    PH_CLOSE
  } phase_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } char_word_t;

  typedef struct packed {
    logic single_label;
    logic intl;
  } cfg_t;

  function automatic logic is_digit(input logic [CODE_W-1:0] c);
    return (c >= 16'h0030) && (c <= 16'h0039);
  endfunction

  function automatic logic is_letter(input logic [CODE_W-1:0] c);
    return ((c >= 16'h0041) && (c <= 16'h005A)) || ((c >= 16'h0061) && (c <= 16'h007A));
  endfunction

  function automatic logic is_hex(input logic [CODE_W-1:0] c);
    return is_digit(c) || ((c >= 16'h0041) && (c <= 16'h0046)) ||
           ((c >= 16'h0061) && (c <= 16'h0066));
  endfunction

  function automatic logic is_special(input logic [CODE_W-1:0] c);
    logic r;
    case (c)
      16'h0021, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027, 16'h002A,
      16'h002B, 16'h002D, 16'h002F, 16'h003D, 16'h003F, 16'h005E, 16'h005F,
      16'h0060, 16'h007B, 16'h007C, 16'h007D, 16'h007E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_atom(input logic [CODE_W-1:0] c, input logic intl);
    logic r;
    if (c >= 16'h0080) begin
      r = intl;
    end else begin
      r = is_letter(c) || is_digit(c) || is_special(c);
    end
    return r;
  endfunction

  // Class bits of a label character, zero when not allowed
  function automatic logic [1:0] label_class(input logic [CODE_W-1:0] c,
                                             input logic first, input logic intl);
    logic [1:0] r;
    if (c >= 16'h0080) begin
      r = intl ? KIND_ALPHA : 2'b00;
    end else if (is_letter(c) || (!first && (c == CH_HYPHEN))) begin
      r = KIND_ALPHA;
    end else if (is_digit(c)) begin
      r = KIND_DIGIT;
    end else begin
      r = 2'b00;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/easc_scan.sv
// Per-character grammar scanner: parse state and the verdict on the last word.
`default_nettype none
module easc_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire easc_pkg::char_word_t word,
  input  wire easc_pkg::cfg_t     cfg,
  output logic                    ok
);

  localparam int CW = easc_pkg::CNT_W;
  localparam int DW = easc_pkg::DEC_W;

  easc_pkg::phase_t phase, phase_next;
  logic [CW-1:0] char_count, char_count_next;
  logic [6:0]    token_length, token_length_next;
  logic          escape_pending, escape_pending_next;
  logic [1:0]    domain_kind, domain_kind_next;
  logic          domain_dot, domain_dot_next;
  logic [CW-1:0] last_at_position, last_at_position_next;
  logic          at_seen, at_seen_next;
  logic [CW-1:0] last_dot_position, last_dot_position_next;
  logic          dot_seen, dot_seen_next;
  logic          prev_hyphen, prev_hyphen_next;
  logic [2:0]    colon_total, colon_total_next;
  logic          compact_seen, compact_seen_next;
  logic [1:0]    colon_run, colon_run_next;
  logic [2:0]    hex_digit_count, hex_digit_count_next;
  logic [DW-1:0] decimal_value, decimal_value_next;
  logic          run_decimal, run_decimal_next;
  logic [1:0]    ipv4_group_count, ipv4_group_count_next;
  logic [CW-1:0] bracket_position, bracket_position_next;
  logic          failed, failed_next;

  logic [easc_pkg::CODE_W-1:0] c;
  logic          stored;
  logic [DW-1:0] dec_step;
  logic [1:0]    cls_first, cls_more;
  logic          v6_ok, v4_handoff_ok, top_ok, end_ok;

  assign c         = word.code;
  assign stored    = char_count < CW'(easc_pkg::MAX_ADDRESS_LENGTH);
  assign dec_step  = DW'({decimal_value, 3'b000}) + DW'({decimal_value, 1'b0}) +
                     DW'(c[3:0]);
  assign cls_first = easc_pkg::label_class(c, 1'b1, cfg.intl);
  assign cls_more  = easc_pkg::label_class(c, 1'b0, cfg.intl);
  assign v6_ok     = (colon_total >= 3'd2) &&
                     (compact_seen ? (colon_total < 3'd7) : (colon_total == 3'd7));
  assign v4_handoff_ok = (hex_digit_count != 3'd0) && (colon_total > 3'd2) &&
                         run_decimal && (hex_digit_count <= 3'd3) &&
                         (decimal_value <= DW'(255)) &&
                         (compact_seen ? (colon_total < 3'd6) : (colon_total == 3'd6));

  always_comb begin
    phase_next             = phase;
    char_count_next        = stored ? char_count + CW'(1) : char_count;
    token_length_next      = token_length;
    escape_pending_next    = escape_pending;
    domain_kind_next       = domain_kind;
    domain_dot_next        = domain_dot;
    last_at_position_next  = last_at_position;
    at_seen_next           = at_seen;
    last_dot_position_next = last_dot_position;
    dot_seen_next          = dot_seen;
    prev_hyphen_next       = prev_hyphen;
    colon_total_next       = colon_total;
    compact_seen_next      = compact_seen;
    colon_run_next         = colon_run;
    hex_digit_count_next   = hex_digit_count;
    decimal_value_next     = decimal_value;
    run_decimal_next       = run_decimal;
    ipv4_group_count_next  = ipv4_group_count;
    bracket_position_next  = bracket_position;
    failed_next            = failed;

    if (stored && (c == easc_pkg::CH_AT)) begin
      last_at_position_next = char_count;
      at_seen_next          = 1'b1;
    end
    if (stored && (c == easc_pkg::CH_DOT)) begin
      last_dot_position_next = char_count;
      dot_seen_next          = 1'b1;
    end

    case (phase)
      easc_pkg::PH_START: begin
        if (c == easc_pkg::CH_QUOTE) begin
          phase_next          = easc_pkg::PH_QUOTED;
          escape_pending_next = 1'b0;
        end else if (easc_pkg::is_atom(c, cfg.intl)) begin
          phase_next = easc_pkg::PH_ATOM;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_QUOTED: begin
        if ((c >= 16'h0080) && !cfg.intl) begin
          failed_next = 1'b1;
        end else if (c == easc_pkg::CH_BSLASH) begin
          escape_pending_next = !escape_pending;
        end else if (!escape_pending && (c == easc_pkg::CH_QUOTE)) begin
          phase_next = easc_pkg::PH_QUOTE_END;
        end else begin
          escape_pending_next = 1'b0;
        end
      end
      easc_pkg::PH_QUOTE_END: begin
        if ((c == easc_pkg::CH_AT) && (char_count <= CW'(easc_pkg::LOCAL_LIMIT))) begin
          phase_next = easc_pkg::PH_DOM_START;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_ATOM_START: begin
        if (easc_pkg::is_atom(c, cfg.intl)) begin
          phase_next = easc_pkg::PH_ATOM;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_ATOM: begin
        if (easc_pkg::is_atom(c, cfg.intl)) begin
          phase_next = easc_pkg::PH_ATOM;
        end else if (c == easc_pkg::CH_DOT) begin
          phase_next = easc_pkg::PH_ATOM_START;
        end else if ((c == easc_pkg::CH_AT) &&
                     (char_count <= CW'(easc_pkg::LOCAL_LIMIT))) begin
          phase_next = easc_pkg::PH_DOM_START;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_DOM_START, easc_pkg::PH_LABEL_START: begin
        if ((phase == easc_pkg::PH_DOM_START) && (c == easc_pkg::CH_LBRACK)) begin
          phase_next            = easc_pkg::PH_LIT_FIRST;
          bracket_position_next = char_count;
        end else if (cls_first != 2'b00) begin
          phase_next        = easc_pkg::PH_LABEL;
          token_length_next = 7'd1;
          prev_hyphen_next  = 1'b0;
          domain_kind_next  = domain_kind | cls_first;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_LABEL: begin
        if (cls_more != 2'b00) begin
          token_length_next = token_length + 7'd1;
          prev_hyphen_next  = (c == easc_pkg::CH_HYPHEN);
          domain_kind_next  = domain_kind | cls_more;
          if (token_length == 7'(easc_pkg::LABEL_LIMIT - 1)) begin
            failed_next = 1'b1;
          end
        end else if ((c == easc_pkg::CH_DOT) && !prev_hyphen) begin
          phase_next      = easc_pkg::PH_LABEL_START;
          domain_dot_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_LIT_FIRST: begin
        hex_digit_count_next  = 3'd0;
        decimal_value_next    = '0;
        ipv4_group_count_next = 2'd0;
        if ((c == 16'h0069) || (c == 16'h0049)) begin
          phase_next        = easc_pkg::PH_TAG;
          token_length_next = 7'd1;
        end else if (easc_pkg::is_digit(c)) begin
          phase_next           = easc_pkg::PH_V4;
          hex_digit_count_next = 3'd1;
          decimal_value_next   = DW'(c[3:0]);
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_TAG: begin
        token_length_next = token_length + 7'd1;
        case (token_length[2:0])
          3'd1: failed_next = failed | !((c == 16'h0070) || (c == 16'h0050));
          3'd2: failed_next = failed | !((c == 16'h0076) || (c == 16'h0056));
          3'd3: failed_next = failed | (c != easc_pkg::CH_SIX);
          3'd4: begin
            failed_next          = failed | (c != easc_pkg::CH_COLON);
            phase_next           = easc_pkg::PH_V6;
            colon_total_next     = 3'd0;
            compact_seen_next    = 1'b0;
            colon_run_next       = 2'd0;
            hex_digit_count_next = 3'd0;
            decimal_value_next   = '0;
            run_decimal_next     = 1'b1;
          end
          default: failed_next = 1'b1;
        endcase
      end
      easc_pkg::PH_V4: begin
        if (easc_pkg::is_digit(c)) begin
          if (hex_digit_count == 3'd3) begin
            failed_next = 1'b1;
          end else begin
            hex_digit_count_next = hex_digit_count + 3'd1;
            decimal_value_next   = dec_step;
          end
        end else if ((c == easc_pkg::CH_DOT) && (hex_digit_count != 3'd0) &&
                     (decimal_value <= DW'(255)) && (ipv4_group_count != 2'd3)) begin
          ipv4_group_count_next = ipv4_group_count + 2'd1;
          hex_digit_count_next  = 3'd0;
          decimal_value_next    = '0;
        end else if ((c == easc_pkg::CH_RBRACK) && (hex_digit_count != 3'd0) &&
                     (decimal_value <= DW'(255)) && (ipv4_group_count == 2'd3)) begin
          phase_next = easc_pkg::PH_CLOSE;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_V6: begin
        if (easc_pkg::is_hex(c)) begin
          colon_run_next = 2'd0;
          if (hex_digit_count == 3'd4) begin
            failed_next = 1'b1;
          end else begin
            hex_digit_count_next = hex_digit_count + 3'd1;
            if (!easc_pkg::is_digit(c)) begin
              run_decimal_next = 1'b0;
            end else if (hex_digit_count < 3'd3) begin
              decimal_value_next = dec_step;
            end
          end
        end else if (c == easc_pkg::CH_COLON) begin
          hex_digit_count_next = 3'd0;
          decimal_value_next   = '0;
          run_decimal_next     = 1'b1;
          colon_total_next     = colon_total + 3'd1;
          colon_run_next       = colon_run + 2'd1;
          if ((colon_total == 3'd7) || (colon_run == 2'd2) ||
              ((colon_run == 2'd1) && compact_seen)) begin
            failed_next = 1'b1;
          end
          if (colon_run == 2'd1) begin
            compact_seen_next = 1'b1;
          end
        end else if ((c == easc_pkg::CH_DOT) && v4_handoff_ok) begin
          // hex run was really the first decimal group of an embedded quad
          phase_next            = easc_pkg::PH_V4;
          ipv4_group_count_next = 2'd1;
          hex_digit_count_next  = 3'd0;
          decimal_value_next    = '0;
        end else if ((c == easc_pkg::CH_RBRACK) && v6_ok) begin
          phase_next = easc_pkg::PH_CLOSE;
        end else begin
          failed_next = 1'b1;
        end
      end
      easc_pkg::PH_CLOSE: failed_next = 1'b1;
      default: failed_next = 1'b1;
    endcase
  end

  assign top_ok = at_seen_next && dot_seen_next &&
                  (last_dot_position_next > last_at_position_next) &&
                  ({1'b0, char_count_next} >=
                   {1'b0, last_dot_position_next} + (CW+1)'(easc_pkg::TOP_LABEL_SPAN));

  always_comb begin
    case (phase_next)
      easc_pkg::PH_LABEL: end_ok = !prev_hyphen_next &&
                                   (domain_dot_next || cfg.single_label) &&
                                   (domain_kind_next != easc_pkg::KIND_DIGIT);
      easc_pkg::PH_CLOSE: end_ok = {1'b0, char_count_next} >=
                                   {1'b0, bracket_position_next} +
                                   (CW+1)'(easc_pkg::MIN_LITERAL_SPAN);
      default:            end_ok = 1'b0;
    endcase
  end

  assign ok = !failed_next && end_ok && top_ok &&
              (char_count_next < CW'(easc_pkg::MAX_ADDRESS_LENGTH));

  always_ff @(posedge clk) begin
    if (rst || (fire && word.last)) begin
      phase            <= easc_pkg::PH_START;
      char_count       <= '0;
      token_length     <= '0;
      escape_pending   <= 1'b0;
      domain_kind      <= 2'b00;
      domain_dot       <= 1'b0;
      last_at_position <= '0;
      at_seen          <= 1'b0;
      last_dot_position <= '0;
      dot_seen         <= 1'b0;
      prev_hyphen      <= 1'b0;
      colon_total      <= '0;
      compact_seen     <= 1'b0;
      colon_run        <= '0;
      hex_digit_count  <= '0;
      decimal_value    <= '0;
      run_decimal      <= 1'b1;
      ipv4_group_count <= '0;
      bracket_position <= '0;
      failed           <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      char_count       <= char_count_next;
      token_length     <= token_length_next;
      escape_pending   <= escape_pending_next;
      domain_kind      <= domain_kind_next;
      domain_dot       <= domain_dot_next;
      last_at_position <= last_at_position_next;
      at_seen          <= at_seen_next;
      last_dot_position <= last_dot_position_next;
      dot_seen         <= dot_seen_next;
      prev_hyphen      <= prev_hyphen_next;
      colon_total      <= colon_total_next;
      compact_seen     <= compact_seen_next;
      colon_run        <= colon_run_next;
      hex_digit_count  <= hex_digit_count_next;
      decimal_value    <= decimal_value_next;
      run_decimal      <= run_decimal_next;
      ipv4_group_count <= ipv4_group_count_next;
      bracket_position <= bracket_position_next;
      failed           <= failed_next;
    end
  end

endmodule
`default_nettype wire

### sv/email_address_syntax_check_unit.sv
// Top level of the address syntax checker: stream ports, config registers, word stages.
`default_nettype none
// Channel   | Dir | Payload                                  | Handshake
// s_axis    | in  | tdata[15:0] char_code, tlast is_last     | tvalid/tready
// m_axis    | out | tdata[0] address_ok, [7:1] zero          | tvalid/tready
// apb       | in  | reg 0 single label @0x0, reg 1 intl @0x4 | psel/penable, pready=1
//
// One character a cycle sustained while no last word waits on an unread
// result; a last word is taken into the input register, then the scanner
// feeds the result register, which holds the verdict until it is read.
// Reset clears parse state, config and valid flags. The result register parts
// the sides: words keep flowing until a last word meets an unread result.
module email_address_syntax_check_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [easc_pkg::CODE_W-1:0]     s_axis_tdata,   // [15:0] char_code
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // [0] address_ok, [7:1] zero
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [easc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  easc_pkg::cfg_t       cfg;
  easc_pkg::char_word_t in_word;
  logic                 in_valid;
  logic                 advance;
  logic                 scan_ok;
  logic                 out_valid;
  logic                 out_ok;
  logic                 cfg_write;

  // Configuration: decode on the word index bit only
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        easc_pkg::REG_SINGLE_LABEL: cfg.single_label <= pwdata[0];
        easc_pkg::REG_INTL:         cfg.intl         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      easc_pkg::REG_SINGLE_LABEL: prdata = {31'b0, cfg.single_label};
      easc_pkg::REG_INTL:         prdata = {31'b0, cfg.intl};
      default:                    prdata = '0;
    endcase
  end

  // Advance the held word unless it is a last word facing an unread result
  assign advance       = in_valid && (!in_word.last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word.code <= s_axis_tdata;
      in_word.last <= s_axis_tlast;
    end
  end

  easc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .word (in_word),
    .cfg  (cfg),
    .ok   (scan_ok)
  );

  // Result register: load on a last word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_word.last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_word.last) begin
      out_ok <= scan_ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_ok};

endmodule
`default_nettype wire
